/* hw/rtl/mmn_pkg.sv */
// Shared types, codes and the Turbo colormap table of the min-max normalizer.
`default_nettype none
package mmn_pkg;

    // Command codes of the input word
    localparam logic [1:0] CMD_BEGIN   = 2'd0;
    localparam logic [1:0] CMD_MEASURE = 2'd1;
    localparam logic [1:0] CMD_CONVERT = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_MAP_MODE      = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_INIT_MIN      = 2'd2;
    localparam logic [1:0] REG_INIT_MAX      = 2'd3;

    localparam logic [7:0] BYTE_MAX = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAS,
        ST_CONV,
        ST_WAIT,
        ST_MAP,
        ST_OUT
    } t_state;

    localparam logic [23:0] TURBO [256] = '{
        {8'd48,8'd18,8'd59},{8'd50,8'd21,8'd67},{8'd51,8'd24,8'd74},{8'd52,8'd27,8'd81},
        {8'd53,8'd30,8'd88},{8'd54,8'd33,8'd95},{8'd55,8'd36,8'd102},{8'd56,8'd39,8'd109},
        {8'd57,8'd42,8'd115},{8'd58,8'd45,8'd121},{8'd59,8'd47,8'd128},{8'd60,8'd50,8'd134},
        {8'd61,8'd53,8'd139},{8'd62,8'd56,8'd145},{8'd63,8'd59,8'd151},{8'd63,8'd62,8'd156},
        {8'd64,8'd64,8'd162},{8'd65,8'd67,8'd167},{8'd65,8'd70,8'd172},{8'd66,8'd73,8'd177},
        {8'd66,8'd75,8'd181},{8'd67,8'd78,8'd186},{8'd68,8'd81,8'd191},{8'd68,8'd84,8'd195},
        {8'd68,8'd86,8'd199},{8'd69,8'd89,8'd203},{8'd69,8'd92,8'd207},{8'd69,8'd94,8'd211},
        {8'd70,8'd97,8'd214},{8'd70,8'd100,8'd218},{8'd70,8'd102,8'd221},{8'd70,8'd105,8'd224},
        {8'd70,8'd107,8'd227},{8'd71,8'd110,8'd230},{8'd71,8'd113,8'd233},{8'd71,8'd115,8'd235},
        {8'd71,8'd118,8'd238},{8'd71,8'd120,8'd240},{8'd71,8'd123,8'd242},{8'd70,8'd125,8'd244},
        {8'd70,8'd128,8'd246},{8'd70,8'd130,8'd248},{8'd70,8'd133,8'd250},{8'd70,8'd135,8'd251},
        {8'd69,8'd138,8'd252},{8'd69,8'd140,8'd253},{8'd68,8'd143,8'd254},{8'd67,8'd145,8'd254},
        {8'd66,8'd148,8'd255},{8'd65,8'd150,8'd255},{8'd64,8'd153,8'd255},{8'd62,8'd155,8'd254},
        {8'd61,8'd158,8'd254},{8'd59,8'd160,8'd253},{8'd58,8'd163,8'd252},{8'd56,8'd165,8'd251},
        {8'd55,8'd168,8'd250},{8'd53,8'd171,8'd248},{8'd51,8'd173,8'd247},{8'd49,8'd175,8'd245},
        {8'd47,8'd178,8'd244},{8'd46,8'd180,8'd242},{8'd44,8'd183,8'd240},{8'd42,8'd185,8'd238},
        {8'd40,8'd188,8'd235},{8'd39,8'd190,8'd233},{8'd37,8'd192,8'd231},{8'd35,8'd195,8'd228},
        {8'd34,8'd197,8'd226},{8'd32,8'd199,8'd223},{8'd31,8'd201,8'd221},{8'd30,8'd203,8'd218},
        {8'd28,8'd205,8'd216},{8'd27,8'd208,8'd213},{8'd26,8'd210,8'd210},{8'd26,8'd212,8'd208},
        {8'd25,8'd213,8'd205},{8'd24,8'd215,8'd202},{8'd24,8'd217,8'd200},{8'd24,8'd219,8'd197},
        {8'd24,8'd221,8'd194},{8'd24,8'd222,8'd192},{8'd24,8'd224,8'd189},{8'd25,8'd226,8'd187},
        {8'd25,8'd227,8'd185},{8'd26,8'd228,8'd182},{8'd28,8'd230,8'd180},{8'd29,8'd231,8'd178},
        {8'd31,8'd233,8'd175},{8'd32,8'd234,8'd172},{8'd34,8'd235,8'd170},{8'd37,8'd236,8'd167},
        {8'd39,8'd238,8'd164},{8'd42,8'd239,8'd161},{8'd44,8'd240,8'd158},{8'd47,8'd241,8'd155},
        {8'd50,8'd242,8'd152},{8'd53,8'd243,8'd148},{8'd56,8'd244,8'd145},{8'd60,8'd245,8'd142},
        {8'd63,8'd246,8'd138},{8'd67,8'd247,8'd135},{8'd70,8'd248,8'd132},{8'd74,8'd248,8'd128},
        {8'd78,8'd249,8'd125},{8'd82,8'd250,8'd122},{8'd85,8'd250,8'd118},{8'd89,8'd251,8'd115},
        {8'd93,8'd252,8'd111},{8'd97,8'd252,8'd108},{8'd101,8'd253,8'd105},{8'd105,8'd253,8'd102},
        {8'd109,8'd254,8'd98},{8'd113,8'd254,8'd95},{8'd117,8'd254,8'd92},{8'd121,8'd254,8'd89},
        {8'd125,8'd255,8'd86},{8'd128,8'd255,8'd83},{8'd132,8'd255,8'd81},{8'd136,8'd255,8'd78},
        {8'd139,8'd255,8'd75},{8'd143,8'd255,8'd73},{8'd146,8'd255,8'd71},{8'd150,8'd254,8'd68},
        {8'd153,8'd254,8'd66},{8'd156,8'd254,8'd64},{8'd159,8'd253,8'd63},{8'd161,8'd253,8'd61},
        {8'd164,8'd252,8'd60},{8'd167,8'd252,8'd58},{8'd169,8'd251,8'd57},{8'd172,8'd251,8'd56},
        {8'd175,8'd250,8'd55},{8'd177,8'd249,8'd54},{8'd180,8'd248,8'd54},{8'd183,8'd247,8'd53},
        {8'd185,8'd246,8'd53},{8'd188,8'd245,8'd52},{8'd190,8'd244,8'd52},{8'd193,8'd243,8'd52},
        {8'd195,8'd241,8'd52},{8'd198,8'd240,8'd52},{8'd200,8'd239,8'd52},{8'd203,8'd237,8'd52},
        {8'd205,8'd236,8'd52},{8'd208,8'd234,8'd52},{8'd210,8'd233,8'd53},{8'd212,8'd231,8'd53},
        {8'd215,8'd229,8'd53},{8'd217,8'd228,8'd54},{8'd219,8'd226,8'd54},{8'd221,8'd224,8'd55},
        {8'd223,8'd223,8'd55},{8'd225,8'd221,8'd55},{8'd227,8'd219,8'd56},{8'd229,8'd217,8'd56},
        {8'd231,8'd215,8'd57},{8'd233,8'd213,8'd57},{8'd235,8'd211,8'd57},{8'd236,8'd209,8'd58},
        {8'd238,8'd207,8'd58},{8'd239,8'd205,8'd58},{8'd241,8'd203,8'd58},{8'd242,8'd201,8'd58},
        {8'd244,8'd199,8'd58},{8'd245,8'd197,8'd58},{8'd246,8'd195,8'd58},{8'd247,8'd193,8'd58},
        {8'd248,8'd190,8'd57},{8'd249,8'd188,8'd57},{8'd250,8'd186,8'd57},{8'd251,8'd184,8'd56},
        {8'd251,8'd182,8'd55},{8'd252,8'd179,8'd54},{8'd252,8'd177,8'd54},{8'd253,8'd174,8'd53},
        {8'd253,8'd172,8'd52},{8'd254,8'd169,8'd51},{8'd254,8'd167,8'd50},{8'd254,8'd164,8'd49},
        {8'd254,8'd161,8'd48},{8'd254,8'd158,8'd47},{8'd254,8'd155,8'd45},{8'd254,8'd153,8'd44},
        {8'd254,8'd150,8'd43},{8'd254,8'd147,8'd42},{8'd254,8'd144,8'd41},{8'd253,8'd141,8'd39},
        {8'd253,8'd138,8'd38},{8'd252,8'd135,8'd37},{8'd252,8'd132,8'd35},{8'd251,8'd129,8'd34},
        {8'd251,8'd126,8'd33},{8'd250,8'd123,8'd31},{8'd249,8'd120,8'd30},{8'd249,8'd117,8'd29},
        {8'd248,8'd114,8'd28},{8'd247,8'd111,8'd26},{8'd246,8'd108,8'd25},{8'd245,8'd105,8'd24},
        {8'd244,8'd102,8'd23},{8'd243,8'd99,8'd21},{8'd242,8'd96,8'd20},{8'd241,8'd93,8'd19},
        {8'd240,8'd91,8'd18},{8'd239,8'd88,8'd17},{8'd237,8'd85,8'd16},{8'd236,8'd83,8'd15},
        {8'd235,8'd80,8'd14},{8'd234,8'd78,8'd13},{8'd232,8'd75,8'd12},{8'd231,8'd73,8'd12},
        {8'd229,8'd71,8'd11},{8'd228,8'd69,8'd10},{8'd226,8'd67,8'd10},{8'd225,8'd65,8'd9},
        {8'd223,8'd63,8'd8},{8'd221,8'd61,8'd8},{8'd220,8'd59,8'd7},{8'd218,8'd57,8'd7},
        {8'd216,8'd55,8'd6},{8'd214,8'd53,8'd6},{8'd212,8'd51,8'd5},{8'd210,8'd49,8'd5},
        {8'd208,8'd47,8'd5},{8'd206,8'd45,8'd4},{8'd204,8'd43,8'd4},{8'd202,8'd42,8'd4},
        {8'd200,8'd40,8'd3},{8'd197,8'd38,8'd3},{8'd195,8'd37,8'd3},{8'd193,8'd35,8'd2},
        {8'd190,8'd33,8'd2},{8'd188,8'd32,8'd2},{8'd185,8'd30,8'd2},{8'd183,8'd29,8'd2},
        {8'd180,8'd27,8'd1},{8'd178,8'd26,8'd1},{8'd175,8'd24,8'd1},{8'd172,8'd23,8'd1},
        {8'd169,8'd22,8'd1},{8'd167,8'd20,8'd1},{8'd164,8'd19,8'd1},{8'd161,8'd18,8'd1},
        {8'd158,8'd16,8'd1},{8'd155,8'd15,8'd1},{8'd152,8'd14,8'd1},{8'd149,8'd13,8'd1},
        {8'd146,8'd11,8'd1},{8'd142,8'd10,8'd1},{8'd139,8'd9,8'd2},{8'd136,8'd8,8'd2},
        {8'd133,8'd7,8'd2},{8'd129,8'd6,8'd2},{8'd126,8'd5,8'd2},{8'd122,8'd4,8'd3}
    };

endpackage
`default_nettype wire

/* hw/rtl/mmn_div.sv */
// Shared serial divider: floor(diff*255/den) clamped to 0..255, one quotient bit a cycle.
`default_nettype none
module mmn_div #(
    parameter int W = 17
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [W-1:0] i_diff,
    input  wire logic        [W-1:0] i_den,
    output logic                     o_done,
    output logic             [7:0]   o_byte
);
    localparam int DW = W + 8;

    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dsh;
    logic [7:0]    r_q;
    logic [DW-1:0] diff_ext;
    logic          ge;

    assign diff_ext = DW'($unsigned(i_diff));
    assign ge       = (r_rem >= r_dsh);

    // Control: start, count eight steps, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_diff <= 0 || $unsigned(i_diff) >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 3'd0;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division of diff*255 by den
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (diff_ext << 8) - diff_ext;
            r_dsh <= DW'(i_den) << 7;
            if (i_diff <= 0) begin
                r_q <= 8'd0;
            end else begin
                r_q <= mmn_pkg::BYTE_MAX;
            end
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[6:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_byte = r_q;
endmodule
`default_nettype wire

/* hw/rtl/minmax_normalize_to_rgb_unit.sv */
// Top level: min-max normalizer with direct RGB scaling or Turbo colormap.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------------
//  input    | in        | i_valid / o_stall   | i_command, i_sample_a/b/c
//  result   | out       | o_valid / i_stall   | o_red, o_green, o_blue, o_range_empty
//  config   | in        | psel/penable/pready | paddr, pwdata, prdata
//
// Begin loads the initial range; measure walks the channels, one min/max compare a cycle.
// Convert runs each channel through the serial divider (then a Turbo lookup for colormap);
// a channel whose quotient is zero or clamps skips the division; an empty range skips all.
// Reset is synchronous, active low; it clears control and loads register defaults.
// o_stall is high while a word is at work; a waiting result holds in the output register
// and blocks the next convert result in ST_OUT, which keeps o_stall high until it is taken.
`default_nettype none
module minmax_normalize_to_rgb_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_a,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_b,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_c,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic                               o_range_empty,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int RW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int DW = RW + 1;

    // Configuration registers
    logic               r_map_mode;
    logic [1:0]         r_chan_cnt;
    logic [15:0]        r_init_min;
    logic [15:0]        r_init_max;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode <= 1'b0;
            r_chan_cnt <= 2'd3;
            r_init_min <= 16'h7FFF;
            r_init_max <= 16'h8000;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                mmn_pkg::REG_MAP_MODE:      r_map_mode <= pwdata[0];
                mmn_pkg::REG_CHANNEL_COUNT: r_chan_cnt <= pwdata[1:0];
                mmn_pkg::REG_INIT_MIN:      r_init_min <= pwdata[15:0];
                mmn_pkg::REG_INIT_MAX:      r_init_max <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mmn_pkg::REG_MAP_MODE:      prdata = {31'd0, r_map_mode};
            mmn_pkg::REG_CHANNEL_COUNT: prdata = {30'd0, r_chan_cnt};
            mmn_pkg::REG_INIT_MIN:      prdata = {16'd0, r_init_min};
            mmn_pkg::REG_INIT_MAX:      prdata = {16'd0, r_init_max};
            default:                    prdata = 32'd0;
        endcase
    end

    // State and datapath registers
    mmn_pkg::t_state        r_state, n_state;
    logic [1:0]             r_ch;
    logic signed [RW-1:0]   r_min, r_max;
    logic signed [SAMPLE_BITS-1:0] r_s [3];
    logic [7:0]             r_byte [3];
    logic                   r_empty;
    logic                   r_out_valid;

    logic                   accept;
    logic [1:0]             used;
    logic signed [RW-1:0]   cur;
    logic signed [DW-1:0]   diff;
    logic [DW-1:0]          den;
    logic                   div_start;
    logic                   div_done;
    logic [7:0]             div_byte;
    logic                   out_free;
    logic [23:0]            rgb;

    assign o_stall  = (r_state != mmn_pkg::ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign used     = r_map_mode ? 2'd1 : r_chan_cnt;
    assign cur      = RW'(r_s[r_ch]);
    assign diff     = DW'(cur) - DW'(r_min);
    assign den      = $unsigned(DW'(r_max) - DW'(r_min));
    assign out_free = !r_out_valid || !i_stall;
    assign rgb      = mmn_pkg::TURBO[r_byte[0]];

    // Next state
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            mmn_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_command == mmn_pkg::CMD_MEASURE) begin
                        n_state = mmn_pkg::ST_MEAS;
                    end else if (i_command == mmn_pkg::CMD_CONVERT) begin
                        n_state = (r_max <= r_min) ? mmn_pkg::ST_OUT : mmn_pkg::ST_CONV;
                    end
                end
            end
            mmn_pkg::ST_MEAS: begin
                if (r_ch >= used) n_state = mmn_pkg::ST_IDLE;
            end
            mmn_pkg::ST_CONV: begin
                if (r_ch < used) begin
                    div_start = 1'b1;
                    n_state   = mmn_pkg::ST_WAIT;
                end else begin
                    n_state = r_map_mode ? mmn_pkg::ST_MAP : mmn_pkg::ST_OUT;
                end
            end
            mmn_pkg::ST_WAIT: begin
                if (div_done) n_state = mmn_pkg::ST_CONV;
            end
            mmn_pkg::ST_MAP:  n_state = mmn_pkg::ST_OUT;
            mmn_pkg::ST_OUT: begin
                if (out_free) n_state = mmn_pkg::ST_IDLE;
            end
            default: n_state = mmn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Running range and channel walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= RW'(16'sh7FFF);
            r_max <= -(RW'(16'sh7FFF)) - RW'(1);
            r_ch  <= 2'd0;
        end else begin
            case (r_state)
                mmn_pkg::ST_IDLE: begin
                    r_ch <= 2'd0;
                    if (accept && i_command == mmn_pkg::CMD_BEGIN) begin
                        r_min <= RW'($signed(r_init_min));
                        r_max <= RW'($signed(r_init_max));
                    end
                end
                mmn_pkg::ST_MEAS: begin
                    if (r_ch < used) begin
                        if (cur < r_min) r_min <= cur;
                        if (cur > r_max) r_max <= cur;
                        r_ch <= r_ch + 2'd1;
                    end
                end
                mmn_pkg::ST_WAIT: begin
                    if (div_done) r_ch <= r_ch + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // Hold samples and bytes of the word at work
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s[0]    <= i_sample_a;
            r_s[1]    <= i_sample_b;
            r_s[2]    <= i_sample_c;
            r_byte[0] <= 8'd0;
            r_byte[1] <= 8'd0;
            r_byte[2] <= 8'd0;
            r_empty   <= (r_max <= r_min);
        end else if (r_state == mmn_pkg::ST_WAIT && div_done) begin
            r_byte[r_ch] <= div_byte;
        end else if (r_state == mmn_pkg::ST_MAP) begin
            r_byte[0] <= rgb[23:16];
            r_byte[1] <= rgb[15:8];
            r_byte[2] <= rgb[7:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == mmn_pkg::ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mmn_pkg::ST_OUT && out_free) begin
            o_red         <= r_byte[0];
            o_green       <= r_byte[1];
            o_blue        <= r_byte[2];
            o_range_empty <= r_empty;
        end
    end

    assign o_valid = r_out_valid;

    mmn_div #(
        .W(DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_diff  (diff),
        .i_den   (den),
        .o_done  (div_done),
        .o_byte  (div_byte)
    );
endmodule
`default_nettype wire

/* verif/tb_minmax_normalize_to_rgb_unit.sv */
// Self-checking testbench of the min-max normalizer: random measure/convert frames, both modes.
`default_nettype none
module tb_minmax_normalize_to_rgb_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic signed [15:0] sample_c;
    } t_pixel_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       range_empty;
    } t_rgb_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_command = '0;
    logic signed [15:0] i_sample_a = '0, i_sample_b = '0, i_sample_c = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [7:0] o_red, o_green, o_blue;
    logic o_range_empty;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    minmax_normalize_to_rgb_unit uut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state: configuration copy and running range
    logic               cfg_colormap = 1'b0;
    logic [1:0]         cfg_channels = 2'd3;
    logic signed [15:0] cfg_min = 16'sh7fff;
    logic signed [15:0] cfg_max = -16'sd32768;
    logic signed [15:0] range_lo = 16'sh7fff;
    logic signed [15:0] range_hi = -16'sd32768;

    t_pixel_word pending_words[$];
    t_rgb_word   expected_pixels[$];
    int  mismatch_count = 0;
    int  pixels_checked = 0;
    int  words_sent = 0;
    bit  calm = 1'b0;
    int  send_gap = 0, recv_gap = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on %s at %0t: got %0d expected %0d", what, $realtime, got, want);
        mismatch_count++;
    endtask

    function automatic logic [7:0] scale_sample(input logic signed [15:0] x);
        longint den, num, q;
        den = longint'(range_hi) - longint'(range_lo);
        num = (longint'(x) - longint'(range_lo)) * 255;
        if (num <= 0 || den <= 0) return 8'd0;
        q = num / den;
        return (q > 255) ? mmn_pkg::BYTE_MAX : q[7:0];
    endfunction

    // Advance the predictor by one accepted word
    task automatic predict_pixel(input t_pixel_word w);
        logic signed [15:0] s[3];
        int used;
        t_rgb_word r;
        logic [7:0] idx;
        s[0] = w.sample_a; s[1] = w.sample_b; s[2] = w.sample_c;
        used = cfg_colormap ? 1 : int'(cfg_channels);
        r = '0;
        case (w.command)
            mmn_pkg::CMD_BEGIN: begin
                range_lo = cfg_min;
                range_hi = cfg_max;
            end
            mmn_pkg::CMD_MEASURE: begin
                for (int i = 0; i < used; i++) begin
                    if (s[i] < range_lo) range_lo = s[i];
                    if (s[i] > range_hi) range_hi = s[i];
                end
            end
            mmn_pkg::CMD_CONVERT: begin
                if (range_hi <= range_lo) begin
                    r.range_empty = 1'b1;
                end else if (cfg_colormap) begin
                    idx = scale_sample(s[0]);
                    {r.red, r.green, r.blue} = mmn_pkg::TURBO[idx];
                end else begin
                    if (used > 0) r.red = scale_sample(s[0]);
                    if (used > 1) r.green = scale_sample(s[1]);
                    if (used > 2) r.blue = scale_sample(s[2]);
                end
                expected_pixels.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Driver: present queued words, with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_pixel({i_command, i_sample_a, i_sample_b, i_sample_c});
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0 &&
                             !(i_valid && !o_stall && !calm && $urandom_range(0, 9) == 0)) begin
                    {i_command, i_sample_a, i_sample_b, i_sample_c} <= pending_words.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                    if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 13);
                end
            end
        end
    end

    // Monitor: check results and throttle the result channel
    always @(posedge i_clk) begin
        t_rgb_word want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    report("unexpected word", 1, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_red != want.red) report("red", o_red, want.red);
                    if (o_green != want.green) report("green", o_green, want.green);
                    if (o_blue != want.blue) report("blue", o_blue, want.blue);
                    if (o_range_empty != want.range_empty)
                        report("range_empty", o_range_empty, want.range_empty);
                    pixels_checked++;
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 12);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {index, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (index)
            mmn_pkg::REG_MAP_MODE:      cfg_colormap = value[0];
            mmn_pkg::REG_CHANNEL_COUNT: cfg_channels = value[1:0];
            mmn_pkg::REG_INIT_MIN:      cfg_min = value[15:0];
            default:                    cfg_max = value[15:0];
        endcase
    endtask

    // Hold until the block is drained, then let a convert finish
    task automatic drain_block();
        while (pending_words.size() > 0 || i_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return -16'sd32768;
            2: return 16'sd0;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_pixel_word make_word(input logic [1:0] cmd);
        return {cmd, pick_sample(), pick_sample(), pick_sample()};
    endfunction

    // Queue one frame: begin, measure pass, convert pass, with optional noise
    task automatic queue_frame(input int pixels, input bit noisy);
        t_pixel_word w;
        pending_words.push_back(make_word(mmn_pkg::CMD_BEGIN));
        for (int i = 0; i < pixels; i++) pending_words.push_back(make_word(mmn_pkg::CMD_MEASURE));
        for (int i = 0; i < pixels; i++) begin
            w = make_word(mmn_pkg::CMD_CONVERT);
            if (noisy && $urandom_range(0, 9) == 0) w.command = 2'd3;
            if (noisy && $urandom_range(0, 19) == 0) w.command = mmn_pkg::CMD_BEGIN;
            pending_words.push_back(w);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty range at reset, extremes, unknown command, direct mode
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh7fff, -16'sd32768, 16'sd0});
        pending_words.push_back({mmn_pkg::CMD_BEGIN, 48'd0});
        pending_words.push_back({mmn_pkg::CMD_MEASURE, -16'sd32768, 16'sh7fff, 16'sd0});
        pending_words.push_back({2'd3, 16'sh1234, 16'sh0, 16'sh0});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, -16'sd32768, 16'sh7fff, 16'sd0});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh7fff, -16'sd32768, -16'sd1});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh5555, 16'shaaaa, 16'sh00ff});
        drain_block();

        // Directed: colormap mode, explicit range with samples outside it
        write_register(mmn_pkg::REG_MAP_MODE, 32'd1);
        write_register(mmn_pkg::REG_INIT_MIN, 32'h0000_ff00);
        write_register(mmn_pkg::REG_INIT_MAX, 32'h0000_0100);
        pending_words.push_back({mmn_pkg::CMD_BEGIN, 48'd0});
        pending_words.push_back({mmn_pkg::CMD_MEASURE, 16'sh0080, 16'sh7fff, -16'sd32768});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh0000, 16'sd0, 16'sd0});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, -16'sd32768, 16'sd0, 16'sd0});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh7fff, 16'sd0, 16'sd0});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh00ff, 16'sd0, 16'sd0});
        drain_block();

        // Directed: channel count zero and one, then equal min and max
        write_register(mmn_pkg::REG_MAP_MODE, 32'd0);
        write_register(mmn_pkg::REG_CHANNEL_COUNT, 32'd0);
        pending_words.push_back({mmn_pkg::CMD_BEGIN, 48'd0});
        pending_words.push_back({mmn_pkg::CMD_MEASURE, 16'sh0100, 16'sh0200, 16'sh0300});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh0100, 16'sh0200, 16'sh0300});
        drain_block();
        write_register(mmn_pkg::REG_CHANNEL_COUNT, 32'd1);
        write_register(mmn_pkg::REG_INIT_MIN, 32'h0000_0040);
        write_register(mmn_pkg::REG_INIT_MAX, 32'h0000_0040);
        pending_words.push_back({mmn_pkg::CMD_BEGIN, 48'd0});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh0040, 16'sh0040, 16'sh0040});
        pending_words.push_back({mmn_pkg::CMD_MEASURE, 16'sh0080, 16'sh7fff, 16'sh7fff});
        pending_words.push_back({mmn_pkg::CMD_CONVERT, 16'sh0060, 16'sh0060, 16'sh0060});
        drain_block();

        // Random phases: new settings between drained phases
        for (int phase = 0; phase < 14; phase++) begin
            write_register(mmn_pkg::REG_MAP_MODE, $urandom_range(0, 3));
            write_register(mmn_pkg::REG_CHANNEL_COUNT, (phase < 3) ? 3 : $urandom());
            case (phase % 3)
                0: begin
                    write_register(mmn_pkg::REG_INIT_MIN, 32'h7fff);
                    write_register(mmn_pkg::REG_INIT_MAX, 32'h8000);
                end
                1: begin
                    write_register(mmn_pkg::REG_INIT_MIN, 32'h8000);
                    write_register(mmn_pkg::REG_INIT_MAX, 32'h7fff);
                end
                default: begin
                    write_register(mmn_pkg::REG_INIT_MIN, $urandom());
                    write_register(mmn_pkg::REG_INIT_MAX, $urandom());
                end
            endcase
            calm = (phase == 13);
            while (pending_words.size() < 100) begin
                queue_frame($urandom_range(1, 8), phase % 2);
            end
            drain_block();
        end

        // Final summary and verdict
        $display("sent %0d words, checked %0d pixels over direct and colormap frames",
                 words_sent, pixels_checked);
        $display("covered empty ranges, out-of-range samples, channel counts 0..3");
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("tb_minmax_normalize_to_rgb_unit passed");
        end else begin
            $display("tb_minmax_normalize_to_rgb_unit failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb_minmax_normalize_to_rgb_unit failed");
        $finish;
    end
endmodule
`default_nettype wire
